// ===== src/arm64_pc_relative_relocator_macros.svh =====
// assertion macros for the pc-relative relocator
// used by the top level; expects i_clk and i_rst_n in the including scope
`ifndef ARM64_PC_RELATIVE_RELOCATOR_MACROS_SVH
`define ARM64_PC_RELATIVE_RELOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define A64PCR_CHK(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("a64pcr check failed");
`define A64PCR_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("a64pcr sequence check failed");
`else
`define A64PCR_CHK(lbl, cond)
`define A64PCR_CHK_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/a64pcr_pkg.sv =====
// shared types and opcode constants for the pc-relative relocator
// no dependencies
`default_nettype none

package a64pcr_pkg;

    typedef enum logic [3:0] {
        KIND_REGULAR = 4'd0,
        KIND_B       = 4'd1,
        KIND_BL      = 4'd2,
        KIND_BCOND   = 4'd3,
        KIND_ADR     = 4'd4,
        KIND_ADRP    = 4'd5,
        KIND_LDR     = 4'd6,
        KIND_CBZ     = 4'd7,
        KIND_TBZ     = 4'd8
    } t_kind;

    localparam logic [31:0] MASK_BRANCH = 32'hFC00_0000;
    localparam logic [31:0] OPC_B       = 32'h1400_0000;
    localparam logic [31:0] OPC_BL      = 32'h9400_0000;
    localparam logic [31:0] MASK_BCOND  = 32'hFF00_0010;
    localparam logic [31:0] OPC_BCOND   = 32'h5400_0000;
    localparam logic [31:0] MASK_ADR    = 32'h9F00_0000;
    localparam logic [31:0] OPC_ADR     = 32'h1000_0000;
    localparam logic [31:0] OPC_ADRP    = 32'h9000_0000;
    localparam logic [31:0] MASK_LDR    = 32'hFF00_0000;
    localparam logic [31:0] OPC_LDR     = 32'h5800_0000;
    localparam logic [31:0] MASK_CMPBR  = 32'h7E00_0000;
    localparam logic [31:0] OPC_CBZ     = 32'h3400_0000;
    localparam logic [31:0] OPC_TBZ     = 32'h3600_0000;
    localparam logic [31:0] KEEP_ADR    = 32'h9F00_001F;

    typedef struct packed {
        t_kind              kind;
        logic [4:0]         dest;
        logic signed [32:0] offset;
    } t_dec;

endpackage

`default_nettype wire

// ===== src/a64pcr_decode.sv =====
// instruction classifier and immediate decoder
// depends on a64pcr_pkg
`default_nettype none

module a64pcr_decode (
    input  wire logic [31:0]      i_instruction,
    output a64pcr_pkg::t_dec      o_dec
);
    import a64pcr_pkg::*;

    logic [31:0]        w;
    logic signed [32:0] off_b;
    logic signed [32:0] off_19;
    logic signed [32:0] off_adr;
    logic signed [32:0] off_adrp;
    logic signed [32:0] off_tb;

    assign w        = i_instruction;
    assign off_b    = {{5{w[25]}}, w[25:0], 2'b00};
    assign off_19   = {{12{w[23]}}, w[23:5], 2'b00};
    assign off_adr  = {{12{w[23]}}, w[23:5], w[30:29]};
    assign off_adrp = {w[23:5], w[30:29], 12'b0};
    assign off_tb   = {{17{w[18]}}, w[18:5], 2'b00};

    // priority follows the encoding overlap order
    always_comb begin
        o_dec.kind   = KIND_REGULAR;
        o_dec.dest   = 5'd0;
        o_dec.offset = 33'sd0;
        if ((w & MASK_BRANCH) == OPC_B) begin
            o_dec.kind   = KIND_B;
            o_dec.offset = off_b;
        end else if ((w & MASK_BRANCH) == OPC_BL) begin
            o_dec.kind   = KIND_BL;
            o_dec.offset = off_b;
        end else if ((w & MASK_BCOND) == OPC_BCOND) begin
            o_dec.kind   = KIND_BCOND;
            o_dec.offset = off_19;
        end else if ((w & MASK_ADR) == OPC_ADR) begin
            o_dec.kind   = KIND_ADR;
            o_dec.dest   = w[4:0];
            o_dec.offset = off_adr;
        end else if ((w & MASK_ADR) == OPC_ADRP) begin
            o_dec.kind   = KIND_ADRP;
            o_dec.dest   = w[4:0];
            o_dec.offset = off_adrp;
        end else if ((w & MASK_LDR) == OPC_LDR) begin
            o_dec.kind   = KIND_LDR;
            o_dec.dest   = w[4:0];
            o_dec.offset = off_19;
        end else if ((w & MASK_CMPBR) == OPC_CBZ) begin
            o_dec.kind   = KIND_CBZ;
            o_dec.offset = off_19;
        end else if ((w & MASK_CMPBR) == OPC_TBZ) begin
            o_dec.kind   = KIND_TBZ;
            o_dec.offset = off_tb;
        end
    end

endmodule

`default_nettype wire

// ===== src/a64pcr_reloc.sv =====
// target distance, range check and re-encoding for b, bl, adr, adrp
// depends on a64pcr_pkg
`default_nettype none

module a64pcr_reloc (
    input  wire logic [31:0]      i_instruction,
    input  wire logic [63:0]      i_original_address,
    input  wire logic [63:0]      i_new_address,
    input  wire a64pcr_pkg::t_dec i_dec,
    output logic [31:0]           o_relocated_word,
    output logic                  o_out_of_range
);
    import a64pcr_pkg::*;

    logic        is_page;
    logic [63:0] base_old;
    logic [63:0] base_new;
    logic [63:0] off64;
    logic [63:0] delta;
    logic        ok_b;
    logic        ok_adr;
    logic        ok_adrp;
    logic        b_top_edge;
    logic [31:0] word_b;
    logic [31:0] word_adr;
    logic [31:0] word_adrp;

    assign is_page  = (i_dec.kind == KIND_ADRP);
    assign base_old = is_page ? {i_original_address[63:12], 12'b0} : i_original_address;
    assign base_new = is_page ? {i_new_address[63:12], 12'b0} : i_new_address;
    assign off64    = {{31{i_dec.offset[32]}}, i_dec.offset};
    // single three-input add, modulo 2^64
    assign delta    = base_old + off64 - base_new;

    // b/bl: 28-bit signed, but the three values just below 2^27 are rejected
    assign b_top_edge = ~delta[63] & (&delta[26:2]) & (|delta[1:0]);
    assign ok_b       = ((&delta[63:27]) | ~(|delta[63:27])) & ~b_top_edge;
    assign ok_adr     = (&delta[63:20]) | ~(|delta[63:20]);
    // page distance is 4k aligned here
    assign ok_adrp    = (&delta[63:32]) | ~(|delta[63:32]);

    assign word_b    = (i_instruction & MASK_BRANCH) | {6'b0, delta[27:2]};
    assign word_adr  = (i_instruction & KEEP_ADR)
                     | {1'b0, delta[1:0], 5'b0, delta[20:2], 5'b0};
    assign word_adrp = (i_instruction & KEEP_ADR)
                     | {1'b0, delta[13:12], 5'b0, delta[32:14], 5'b0};

    always_comb begin
        o_relocated_word = i_instruction;
        o_out_of_range   = 1'b0;
        case (i_dec.kind)
            KIND_B, KIND_BL: begin
                o_relocated_word = ok_b ? word_b : 32'd0;
                o_out_of_range   = ~ok_b;
            end
            KIND_ADR: begin
                o_relocated_word = ok_adr ? word_adr : 32'd0;
                o_out_of_range   = ~ok_adr;
            end
            KIND_ADRP: begin
                o_relocated_word = ok_adrp ? word_adrp : 32'd0;
                o_out_of_range   = ~ok_adrp;
            end
            default: begin
                o_relocated_word = i_instruction;
                o_out_of_range   = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/arm64_pc_relative_relocator.sv =====
// top level of the arm64 pc-relative relocator: input register, decode, relocate, result register
// depends on a64pcr_pkg, a64pcr_decode, a64pcr_reloc and the assertion macro header
//
// usage:
//   a request is taken at a rising edge with start high and busy low. it carries
//   one instruction word, the address it came from and the address it moves to.
//   busy is low whenever reset is released, so a request can be issued every cycle.
//   o_valid rises at the edge after the accepting edge and is high for exactly one
//   cycle with o_kind, o_dest_register, o_decoded_offset, o_relocated_word and
//   o_out_of_range.
//   the receiver cannot stall, so results must be captured in the cycle they are shown.
//   throughput: one request per cycle, set by the single decode/add/compare pass
//   between the input register and the result register (one 64-bit three-input add).
//   a request passes the input register, then decode and relocate, then the result register.
//   reset: synchronous, active low; clears the valid flags of both register
//   stages, so no result is shown for requests still in flight. busy is high
//   while reset is asserted.
`default_nettype none

`include "arm64_pc_relative_relocator_macros.svh"

module arm64_pc_relative_relocator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [31:0]        i_instruction,
    input  wire logic [63:0]        i_original_address,
    input  wire logic [63:0]        i_new_address,
    output logic                    o_valid,
    output logic [3:0]              o_kind,
    output logic [4:0]              o_dest_register,
    output logic signed [32:0]      o_decoded_offset,
    output logic [31:0]             o_relocated_word,
    output logic                    o_out_of_range
);
    import a64pcr_pkg::*;

    logic        r_in_valid;
    logic [31:0] r_instruction;
    logic [63:0] r_original_address;
    logic [63:0] r_new_address;

    logic               r_valid;
    logic [3:0]         r_kind;
    logic [4:0]         r_dest_register;
    logic signed [32:0] r_decoded_offset;
    logic [31:0]        r_relocated_word;
    logic               r_out_of_range;

    logic        n_accept;
    t_dec        dec;
    logic [31:0] reloc_word;
    logic        reloc_oor;

    assign busy     = ~i_rst_n;
    assign n_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_accept;
        end
        if (n_accept) begin
            r_instruction      <= i_instruction;
            r_original_address <= i_original_address;
            r_new_address      <= i_new_address;
        end
    end

    a64pcr_decode u_decode (
        .i_instruction (r_instruction),
        .o_dec         (dec)
    );

    a64pcr_reloc u_reloc (
        .i_instruction      (r_instruction),
        .i_original_address (r_original_address),
        .i_new_address      (r_new_address),
        .i_dec              (dec),
        .o_relocated_word   (reloc_word),
        .o_out_of_range     (reloc_oor)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_kind           <= dec.kind;
            r_dest_register  <= dec.dest;
            r_decoded_offset <= dec.offset;
            r_relocated_word <= reloc_word;
            r_out_of_range   <= reloc_oor;
        end
    end

    assign o_valid          = r_valid;
    assign o_kind           = r_kind;
    assign o_dest_register  = r_dest_register;
    assign o_decoded_offset = r_decoded_offset;
    assign o_relocated_word = r_relocated_word;
    assign o_out_of_range   = r_out_of_range;

    // every accepted request reaches r_in_valid and then o_valid; o_valid never rises without r_in_valid
    `A64PCR_CHK_NEXT(a_accept_to_stage, n_accept, r_in_valid)
    `A64PCR_CHK_NEXT(a_stage_to_result, r_in_valid, o_valid)
    `A64PCR_CHK_NEXT(a_no_phantom, !r_in_valid, !o_valid)
    // a range failure only comes from a relocatable kind and always zeroes the word
    `A64PCR_CHK(a_oor_kind,
        !(o_valid && o_out_of_range) || ((o_relocated_word == 32'd0)
        && ((o_kind == KIND_B) || (o_kind == KIND_BL)
        || (o_kind == KIND_ADR) || (o_kind == KIND_ADRP))))
    // only adr, adrp and ldr literal carry a register
    `A64PCR_CHK(a_dest_kind,
        !(o_valid && (o_dest_register != 5'd0))
        || ((o_kind == KIND_ADR) || (o_kind == KIND_ADRP) || (o_kind == KIND_LDR)))

endmodule

`default_nettype wire
